// ===== hdl/length_prefixed_frame_extractor_assert.svh =====
// Assertion macros shared by the frame extractor modules.
`ifndef LENGTH_PREFIXED_FRAME_EXTRACTOR_ASSERT_SVH
`define LENGTH_PREFIXED_FRAME_EXTRACTOR_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define LPFE_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define LPFE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/lpfe_pkg.sv =====
// Types and constants shared by the frame extractor modules.
package lpfe_pkg;

  // Register file geometry: 64-bit registers at 8-byte stride.
  localparam int ADDR_W = 6;
  localparam int DATA_W = 64;

  // Register indexes.
  localparam logic [2:0] REG_HEAD_LENGTH  = 3'd0;
  localparam logic [2:0] REG_HEAD_PATTERN = 3'd1;
  localparam logic [2:0] REG_TAIL_LENGTH  = 3'd2;
  localparam logic [2:0] REG_TAIL_PATTERN = 3'd3;
  localparam logic [2:0] REG_LEN_BYTES    = 3'd4;
  localparam logic [2:0] REG_MAX_PAYLOAD  = 3'd5;

  // Result word kinds and frame status codes.
  localparam logic       KIND_DATA   = 1'b0;
  localparam logic       KIND_END    = 1'b1;
  localparam logic [1:0] ST_GOOD     = 2'd0;
  localparam logic [1:0] ST_TAIL_BAD = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;

  // Entries in the queue between classifier and output stage.
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_kind;
    logic [1:0] frame_status;
  } res_t;

  typedef struct packed {
    logic [3:0]  head_length;
    logic [63:0] head_pattern;
    logic [3:0]  tail_length;
    logic [63:0] tail_pattern;
    logic [2:0]  length_field_bytes;
    logic [31:0] max_payload;
  } cfg_t;

endpackage

// ===== hdl/lpfe_if.sv =====
// Stream channel interfaces: raw byte input and result word output.
interface lpfe_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface lpfe_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_kind;
  logic [1:0] frame_status;

  modport source (output valid, output out_byte, output out_kind, output frame_status,
                  input ready);
  modport sink (input valid, input out_byte, input out_kind, input frame_status,
                output ready);
endinterface

// ===== hdl/lpfe_regs.sv =====
// APB configuration register file of the frame extractor.
module lpfe_regs import lpfe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:3];
  assign cfg_o   = cfg_q;

  // Write the addressed register on the access cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.head_length        <= 4'd2;
      cfg_q.head_pattern       <= '0;
      cfg_q.tail_length        <= 4'd2;
      cfg_q.tail_pattern       <= '0;
      cfg_q.length_field_bytes <= 3'd4;
      cfg_q.max_payload        <= 32'd65535;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_HEAD_LENGTH:  cfg_q.head_length        <= pwdata[3:0];
        REG_HEAD_PATTERN: cfg_q.head_pattern       <= pwdata;
        REG_TAIL_LENGTH:  cfg_q.tail_length        <= pwdata[3:0];
        REG_TAIL_PATTERN: cfg_q.tail_pattern       <= pwdata;
        REG_LEN_BYTES:    cfg_q.length_field_bytes <= pwdata[2:0];
        REG_MAX_PAYLOAD:  cfg_q.max_payload        <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  // Return the addressed register, zero beyond the list.
  always_comb begin
    unique case (reg_idx)
      REG_HEAD_LENGTH:  prdata = DATA_W'(cfg_q.head_length);
      REG_HEAD_PATTERN: prdata = cfg_q.head_pattern;
      REG_TAIL_LENGTH:  prdata = DATA_W'(cfg_q.tail_length);
      REG_TAIL_PATTERN: prdata = cfg_q.tail_pattern;
      REG_LEN_BYTES:    prdata = DATA_W'(cfg_q.length_field_bytes);
      REG_MAX_PAYLOAD:  prdata = DATA_W'(cfg_q.max_payload);
      default:          prdata = '0;
    endcase
  end

endmodule

// ===== hdl/lpfe_front.sv =====
// Front end: header hunt, length parse, payload pass and tail check per byte.
`include "length_prefixed_frame_extractor_assert.svh"
module lpfe_front import lpfe_pkg::*; #(
  parameter int MAX_MARK_BYTES   = 8,
  parameter int MAX_LENGTH_BYTES = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  lpfe_byte_if.sink   in_i,
  input  logic        full_i,
  output logic        push_o,
  output res_t        res_o
);

  localparam int MW = 8 * MAX_MARK_BYTES;
  localparam int LW = 8 * MAX_LENGTH_BYTES;
  localparam int FW = $clog2(MAX_MARK_BYTES + 1);

  localparam logic [1:0] PH_HUNT    = 2'd0;
  localparam logic [1:0] PH_LENGTH  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;
  localparam logic [1:0] PH_TAIL    = 2'd3;

  logic [1:0]    phase_q, phase_d;
  logic [MW-1:0] win_q, win_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [LW-1:0] cnt_q, cnt_d;
  logic [LW-1:0] plen_q, plen_d;
  logic          tail_ok_q, tail_ok_d;

  logic                      acc;
  logic [7:0]                b;
  logic [3:0]                h4, t4;
  logic [2:0]                n3;
  logic [FW-1:0]             h_fw;
  logic [LW-1:0]             t_ext, n_ext, cnt_inc, plen_next;
  logic [MW-1:0]             win_base, win_new;
  logic [FW-1:0]             fill_base, fill_new;
  logic [MAX_MARK_BYTES-1:0] byte_ok;
  logic                      hunt_match;
  logic [2:0]                tail_idx;
  logic [7:0]                exp_byte;
  logic                      res_valid;

  assign in_i.ready = !full_i;
  assign acc        = in_i.valid && !full_i;
  assign b          = in_i.in_byte;
  assign push_o     = acc && res_valid;

  // Clamp the configured lengths to their legal ranges.
  always_comb begin
    if (cfg_i.head_length == 4'd0) begin
      h4 = 4'd1;
    end else if (cfg_i.head_length > 4'(MAX_MARK_BYTES)) begin
      h4 = 4'(MAX_MARK_BYTES);
    end else begin
      h4 = cfg_i.head_length;
    end
    if (cfg_i.tail_length > 4'(MAX_MARK_BYTES)) begin
      t4 = 4'(MAX_MARK_BYTES);
    end else begin
      t4 = cfg_i.tail_length;
    end
    if (cfg_i.length_field_bytes == 3'd0) begin
      n3 = 3'd1;
    end else if (cfg_i.length_field_bytes > 3'(MAX_LENGTH_BYTES)) begin
      n3 = 3'(MAX_LENGTH_BYTES);
    end else begin
      n3 = cfg_i.length_field_bytes;
    end
  end

  assign h_fw      = FW'(h4);
  assign t_ext     = LW'(t4);
  assign n_ext     = LW'(n3);
  assign cnt_inc   = cnt_q + 1'b1;
  assign plen_next = LW'({plen_q, b});

  // Shift the byte into the window; the window restarts empty after a frame end.
  assign win_base  = (phase_q == PH_TAIL) ? '0 : win_q;
  assign fill_base = (phase_q == PH_TAIL) ? '0 : fill_q;
  assign win_new   = MW'({win_base, b});
  assign fill_new  = (fill_base < FW'(MAX_MARK_BYTES)) ? fill_base + 1'b1 : fill_base;

  // Compare the newest head bytes with the header, one comparator per byte.
  always_comb begin
    for (int k = 0; k < MAX_MARK_BYTES; k++) begin
      byte_ok[k] = (FW'(k) >= h_fw) || (win_new[8*k +: 8] == cfg_i.head_pattern[8*k +: 8]);
    end
  end
  assign hunt_match = (fill_new >= h_fw) && (&byte_ok);

  // Pick the expected tail byte, first byte in the highest used position.
  assign tail_idx = 3'(t4 - 4'd1 - cnt_q[3:0]);
  assign exp_byte = cfg_i.tail_pattern[{tail_idx, 3'b000} +: 8];

  // Next state and result for the byte on the input.
  always_comb begin
    phase_d   = phase_q;
    win_d     = win_q;
    fill_d    = fill_q;
    cnt_d     = cnt_q;
    plen_d    = plen_q;
    tail_ok_d = tail_ok_q;
    res_valid = 1'b0;
    res_o     = '0;
    unique case (phase_q)
      PH_HUNT: begin
        win_d  = win_new;
        fill_d = fill_new;
        if (hunt_match) begin
          phase_d = PH_LENGTH;
          cnt_d   = '0;
          plen_d  = '0;
          win_d   = '0;
          fill_d  = '0;
        end
      end
      PH_LENGTH: begin
        plen_d = plen_next;
        cnt_d  = cnt_inc;
        if (cnt_inc >= n_ext) begin
          cnt_d = '0;
          if (32'(plen_next) > cfg_i.max_payload) begin
            res_valid          = 1'b1;
            res_o.out_kind     = KIND_END;
            res_o.frame_status = ST_TOO_LONG;
            phase_d            = PH_HUNT;
            win_d              = '0;
            fill_d             = '0;
          end else begin
            tail_ok_d = 1'b1;
            phase_d   = (plen_next == '0) ? PH_TAIL : PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        res_valid      = 1'b1;
        res_o.out_byte = b;
        res_o.out_kind = KIND_DATA;
        cnt_d          = cnt_inc;
        if (cnt_inc >= plen_q) begin
          cnt_d     = '0;
          tail_ok_d = 1'b1;
          phase_d   = PH_TAIL;
        end
      end
      PH_TAIL: begin
        res_valid = 1'b1;
        res_o.out_kind = KIND_END;
        if (cnt_q >= t_ext) begin
          // Tail already complete: end the frame and hunt with this byte.
          res_o.frame_status = tail_ok_q ? ST_GOOD : ST_TAIL_BAD;
          phase_d            = PH_HUNT;
          cnt_d              = '0;
          win_d              = win_new;
          fill_d             = fill_new;
          if (hunt_match) begin
            phase_d = PH_LENGTH;
            plen_d  = '0;
            win_d   = '0;
            fill_d  = '0;
          end
        end else begin
          tail_ok_d = tail_ok_q && (exp_byte == b);
          cnt_d     = cnt_inc;
          if (cnt_inc >= t_ext) begin
            res_o.frame_status = tail_ok_d ? ST_GOOD : ST_TAIL_BAD;
            phase_d            = PH_HUNT;
            cnt_d              = '0;
            win_d              = '0;
            fill_d             = '0;
          end else begin
            res_valid = 1'b0;
            res_o     = '0;
          end
        end
      end
    endcase
  end

  // Advance the frame state on each accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HUNT;
      win_q     <= '0;
      fill_q    <= '0;
      cnt_q     <= '0;
      plen_q    <= '0;
      tail_ok_q <= 1'b1;
    end else if (acc) begin
      phase_q   <= phase_d;
      win_q     <= win_d;
      fill_q    <= fill_d;
      cnt_q     <= cnt_d;
      plen_q    <= plen_d;
      tail_ok_q <= tail_ok_d;
    end
  end

  `LPFE_ASSERT_IMPLY(a_payload_passes, acc && (phase_q == PH_PAYLOAD), push_o && (res_o.out_kind == KIND_DATA) && (res_o.out_byte == in_i.in_byte), "payload byte not passed through")
  `LPFE_ASSERT_IMPLY(a_hunt_silent, acc && (phase_q == PH_HUNT), !push_o, "result produced while hunting")
  `LPFE_ASSERT_IMPLY(a_tail_count_bound, phase_q == PH_TAIL, cnt_q <= LW'(MAX_MARK_BYTES), "tail count past maximum tail")

endmodule

// ===== hdl/lpfe_queue.sv =====
// Short result queue between the classifier and the output stage.
`include "length_prefixed_frame_extractor_assert.svh"
module lpfe_queue import lpfe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t res_i,
  output logic full_o,
  input  logic pop_i,
  output logic avail_o,
  output res_t res_o
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  res_t          mem_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;

  assign full_o  = (cnt_q == CW'(QUEUE_DEPTH));
  assign avail_o = (cnt_q != '0);
  assign res_o   = mem_q[rd_ptr_q];

  // Store a pushed word; entries need no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= res_i;
    end
  end

  // Advance pointers and occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `LPFE_ASSERT_IMPLY(a_no_overflow, push_i, !full_o, "push into full queue")
  `LPFE_ASSERT_IMPLY(a_no_underflow, pop_i, avail_o, "pop from empty queue")
  `LPFE_ASSERT_NEXT(a_fill_up, push_i && !pop_i, cnt_q == $past(cnt_q) + 1'b1, "queue count did not grow on push")

endmodule

// ===== hdl/lpfe_back.sv =====
// Back end: output register that drains the queue onto the result channel.
module lpfe_back import lpfe_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           avail_i,
  input  res_t           res_i,
  output logic           pop_o,
  lpfe_result_if.source  out_o
);

  logic val_q;
  res_t data_q;

  // Load a new word when the register is empty or being taken.
  assign pop_o = avail_i && (!val_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= 1'b0;
    end else if (pop_o) begin
      val_q <= 1'b1;
    end else if (out_o.ready) begin
      val_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= res_i;
    end
  end

  assign out_o.valid        = val_q;
  assign out_o.out_byte     = data_q.out_byte;
  assign out_o.out_kind     = data_q.out_kind;
  assign out_o.frame_status = data_q.frame_status;

endmodule

// ===== hdl/length_prefixed_frame_extractor.sv =====
// Each result word passes the result queue and then the output register on its way to out_o.
// Throughput: one byte per cycle; the per-byte classifier holds all frame state in one step.
// A two-entry result queue and the output register absorb output stalls; in_i.ready
// drops only when the queue is full.
// Reset (rst_ni low, asynchronous): hunting for a header, empty window, registers at defaults.
module length_prefixed_frame_extractor import lpfe_pkg::*; #(
  parameter int MAX_MARK_BYTES   = 8,
  parameter int MAX_LENGTH_BYTES = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  lpfe_byte_if.sink         in_i,
  lpfe_result_if.source     out_o
);

  cfg_t cfg;
  logic push, full, pop, avail;
  res_t front_res, queue_res;

  lpfe_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lpfe_front #(
    .MAX_MARK_BYTES   (MAX_MARK_BYTES),
    .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .res_o  (front_res)
  );

  lpfe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .res_i   (front_res),
    .full_o  (full),
    .pop_i   (pop),
    .avail_o (avail),
    .res_o   (queue_res)
  );

  lpfe_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .avail_i (avail),
    .res_i   (queue_res),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
